/* sv/hs_pkg.sv */
package hs_pkg;

    localparam int LEVELS     = 256;
    localparam int LVL_W      = 8;
    localparam int CNT_W      = 25;
    localparam int PROD_W     = 2 * CNT_W;
    localparam logic [CNT_W-1:0] MAX_PIXELS = CNT_W'(25'd16777216);

    typedef enum logic [2:0] {
        K_SRC   = 3'd0,
        K_REF   = 3'd1,
        K_BUILD = 3'd2,
        K_MAP   = 3'd3,
        K_CLEAR = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_COUNT,
        S_MAP,
        S_CLEAR,
        S_ZERO,
        S_PFX,
        S_ROW_RD,
        S_ROW_ACC,
        S_ROW_MUL,
        S_SCAN,
        S_DRAIN
    } t_state;

endpackage

/* sv/hs_ram.sv */
module hs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/histogram_specification.sv */
// Channel   Ports                          Handshake
// -------   -----------------------------  ------------------------------------
// command   start, i_kind, i_pixel         word taken when start & !busy
// result    o_strobe, o_mapped_value       one word per o_strobe cycle, no stall
//
// Count, map and unused kinds: RAM read, then write back or result.
// Clear: one bin of each histogram zeroed per cycle.
// Build: prefix sum of the reference, then per source level the setup states
//   S_ROW_RD, S_ROW_ACC, S_ROW_MUL, a scan of the cumulative reference RAM, and a drain.
//   With an empty total the build instead writes zero to every map entry.
// After reset, busy stays high while histograms clear and the map
//   loads the identity. The result side cannot stall; results go out directly.
module histogram_specification
    import hs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [2:0]       i_kind,
    input  logic [LVL_W-1:0] i_pixel,
    output logic             o_strobe,
    output logic [LVL_W-1:0] o_mapped_value
);

    t_state r_state, n_state;

    logic             accept;
    logic [LVL_W-1:0] r_j, r_i, r_pix, r_pj, r_j1, r_j2, r_j3, r_bestj;
    logic [2:0]       r_kind;
    logic [CNT_W-1:0] r_src_total, r_ref_total, r_acc_r, r_acc_s;
    logic [PROD_W-1:0] r_a, r_prod, r_diff, r_best;
    logic             r_pv, r_v1, r_v2, r_v3;
    logic             drained;

    // RAM control
    logic             src_we, ref_we, cum_we, map_we;
    logic [LVL_W-1:0] src_waddr, ref_waddr, map_waddr, src_raddr, ref_raddr;
    logic [CNT_W-1:0] src_wdata, ref_wdata;
    logic [LVL_W-1:0] map_wdata;
    logic [CNT_W-1:0] src_rdata, ref_rdata, cum_rdata;
    logic [LVL_W-1:0] map_rdata;

    assign accept  = start && !busy;
    assign drained = !r_v1 && !r_v2 && !r_v3;

    hs_ram #(.WIDTH(CNT_W), .DEPTH(LEVELS)) u_src (
        .i_clk(i_clk), .i_we(src_we), .i_waddr(src_waddr), .i_wdata(src_wdata),
        .i_raddr(src_raddr), .o_rdata(src_rdata)
    );
    hs_ram #(.WIDTH(CNT_W), .DEPTH(LEVELS)) u_ref (
        .i_clk(i_clk), .i_we(ref_we), .i_waddr(ref_waddr), .i_wdata(ref_wdata),
        .i_raddr(ref_raddr), .o_rdata(ref_rdata)
    );
    // cumulative reference histogram, filled during build
    hs_ram #(.WIDTH(CNT_W), .DEPTH(LEVELS)) u_cum (
        .i_clk(i_clk), .i_we(cum_we), .i_waddr(r_pj), .i_wdata(r_acc_r + ref_rdata),
        .i_raddr(r_j), .o_rdata(cum_rdata)
    );
    hs_ram #(.WIDTH(LVL_W), .DEPTH(LEVELS)) u_map (
        .i_clk(i_clk), .i_we(map_we), .i_waddr(map_waddr), .i_wdata(map_wdata),
        .i_raddr(i_pixel), .o_rdata(map_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT, S_CLEAR, S_ZERO: begin
                if (r_j == LVL_W'(LEVELS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (t_kind'(i_kind))
                        K_SRC, K_REF: n_state = S_COUNT;
                        K_MAP:        n_state = S_MAP;
                        K_CLEAR:      n_state = S_CLEAR;
                        K_BUILD: begin
                            if (r_src_total == '0 || r_ref_total == '0) n_state = S_ZERO;
                            else n_state = S_PFX;
                        end
                        default:      n_state = S_COUNT;
                    endcase
                end
            end
            S_COUNT, S_MAP: n_state = S_IDLE;
            S_PFX: begin
                if (r_j == LVL_W'(LEVELS - 1)) n_state = S_ROW_RD;
            end
            S_ROW_RD:  n_state = S_ROW_ACC;
            S_ROW_ACC: n_state = S_ROW_MUL;
            S_ROW_MUL: n_state = S_SCAN;
            S_SCAN: begin
                if (r_j == LVL_W'(LEVELS - 1)) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (drained) begin
                    if (r_i == LVL_W'(LEVELS - 1)) n_state = S_IDLE;
                    else n_state = S_ROW_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and RAM control
    always_comb begin
        busy      = (r_state != S_IDLE);
        o_strobe  = (r_state == S_MAP);
        o_mapped_value = map_rdata;

        src_raddr = (r_state == S_ROW_RD) ? r_i : i_pixel;
        ref_raddr = (r_state == S_PFX) ? r_j : i_pixel;
        cum_we    = r_pv;

        src_we    = 1'b0;
        ref_we    = 1'b0;
        src_waddr = r_j;
        ref_waddr = r_j;
        src_wdata = '0;
        ref_wdata = '0;
        map_we    = 1'b0;
        map_waddr = r_j;
        map_wdata = '0;

        unique case (r_state)
            S_INIT: begin
                src_we    = 1'b1;
                ref_we    = 1'b1;
                map_we    = 1'b1;
                map_wdata = r_j;
            end
            S_CLEAR: begin
                src_we = 1'b1;
                ref_we = 1'b1;
            end
            S_ZERO: map_we = 1'b1;
            S_COUNT: begin
                src_waddr = r_pix;
                ref_waddr = r_pix;
                src_wdata = src_rdata + CNT_W'(1);
                ref_wdata = ref_rdata + CNT_W'(1);
                src_we = (r_kind == K_SRC) && (r_src_total != MAX_PIXELS);
                ref_we = (r_kind == K_REF) && (r_ref_total != MAX_PIXELS);
            end
            S_DRAIN: begin
                map_we    = drained;
                map_waddr = r_i;
                map_wdata = r_bestj;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_j         <= '0;
            r_i         <= '0;
            r_pv        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_src_total <= '0;
            r_ref_total <= '0;
        end else begin
            r_state <= n_state;
            r_pv    <= (r_state == S_PFX);
            r_v1    <= (r_state == S_SCAN);
            r_v2    <= r_v1;
            r_v3    <= r_v2;

            priority case (r_state)
                S_INIT, S_CLEAR, S_ZERO, S_PFX, S_SCAN: r_j <= r_j + LVL_W'(1);
                default: r_j <= '0;
            endcase

            if (r_state == S_IDLE) begin
                r_i <= '0;
            end else if (r_state == S_DRAIN && drained) begin
                r_i <= r_i + LVL_W'(1);
            end

            if (r_state == S_CLEAR) begin
                r_src_total <= '0;
                r_ref_total <= '0;
            end else if (r_state == S_COUNT) begin
                if (src_we) r_src_total <= r_src_total + CNT_W'(1);
                if (ref_we) r_ref_total <= r_ref_total + CNT_W'(1);
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix  <= i_pixel;
            r_kind <= i_kind;
        end
        r_pj <= r_j;
        if (r_state == S_IDLE) begin
            r_acc_r <= '0;
            r_acc_s <= '0;
        end else begin
            if (r_pv) r_acc_r <= r_acc_r + ref_rdata;
            if (r_state == S_ROW_ACC) r_acc_s <= r_acc_s + src_rdata;
        end
        // Ssrc_i * Nref for this row
        if (r_state == S_ROW_MUL) r_a <= r_acc_s * r_ref_total;
        // scan: Sref_j * Nsrc, then |diff|, then keep first minimum
        r_j1   <= r_j;
        r_j2   <= r_j1;
        r_j3   <= r_j2;
        r_prod <= cum_rdata * r_src_total;
        r_diff <= (r_a >= r_prod) ? (r_a - r_prod) : (r_prod - r_a);
        if (r_v3 && (r_j3 == '0 || r_diff < r_best)) begin
            r_best  <= r_diff;
            r_bestj <= r_j3;
        end
    end

    // a map word yields exactly one strobe, from the S_MAP state that follows its acceptance
    a_map_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_kind == K_MAP) |-> ##1 o_strobe)
        else $error("map word without result");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    a_total_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_src_total <= MAX_PIXELS) && (r_ref_total <= MAX_PIXELS))
        else $error("histogram total beyond saturation");

    // prefix writes must be finished before the scan reads the cumulative RAM
    a_cum_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !r_pv)
        else $error("cumulative write overlaps scan");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench
    import hs_pkg::*;
();

    // Kinds the block must ignore: no state change, no result.
    localparam logic [2:0] K_SPARE0 = 3'd5;
    localparam logic [2:0] K_SPARE1 = 3'd6;
    localparam logic [2:0] K_SPARE2 = 3'd7;

    // A build scans every reference level for each source level with nothing accepted; leave ample room.
    localparam int STALL_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 40;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [2:0]       i_kind;
    logic [LVL_W-1:0] i_pixel;
    logic             o_strobe;
    logic [LVL_W-1:0] o_mapped_value;

    histogram_specification u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_pixel        (i_pixel),
        .o_strobe       (o_strobe),
        .o_mapped_value (o_mapped_value)
    );

    // Shadow state of the matcher.
    logic [CNT_W-1:0] src_bins [LEVELS];
    logic [CNT_W-1:0] ref_bins [LEVELS];
    logic [LVL_W-1:0] lut      [LEVELS];
    logic [CNT_W-1:0] src_count;
    logic [CNT_W-1:0] ref_count;

    logic [LVL_W-1:0] mapped_q [$];   // expected mapped levels, oldest first
    int  fail_count;
    bit  no_gaps;                     // sender runs back to back when set
    int  idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Recompute the whole level map from the shadow histograms.
    task automatic rebuild_lut();
        longint unsigned cum_src [LEVELS];
        longint unsigned cum_ref [LEVELS];
        longint unsigned acc_s, acc_r, lhs, rhs, diff, best_diff;
        int best;
        acc_s = 0;
        acc_r = 0;
        if (src_count == 0 || ref_count == 0) begin
            // one empty side: every level maps to 0
            foreach (lut[i]) lut[i] = '0;
            return;
        end
        for (int i = 0; i < LEVELS; i++) begin
            acc_s += src_bins[i];
            acc_r += ref_bins[i];
            cum_src[i] = acc_s;
            cum_ref[i] = acc_r;
        end
        for (int i = 0; i < LEVELS; i++) begin
            lhs = cum_src[i] * longint'(ref_count);
            best = 0;
            best_diff = 0;
            for (int j = 0; j < LEVELS; j++) begin
                rhs = cum_ref[j] * longint'(src_count);
                diff = (lhs >= rhs) ? lhs - rhs : rhs - lhs;
                // strict less-than keeps the lowest level on a tie
                if (j == 0 || diff < best_diff) begin
                    best_diff = diff;
                    best = j;
                end
            end
            lut[i] = best[LVL_W-1:0];
        end
    endtask

    // Update the shadow state for one accepted word.
    task automatic predict_word(logic [2:0] kind, logic [LVL_W-1:0] pix);
        case (kind)
            K_SRC: begin
                if (src_count < MAX_PIXELS) begin
                    src_bins[pix]++;
                    src_count++;
                end
            end
            K_REF: begin
                if (ref_count < MAX_PIXELS) begin
                    ref_bins[pix]++;
                    ref_count++;
                end
            end
            K_BUILD: rebuild_lut();
            K_MAP:   mapped_q = {mapped_q, lut[pix]};
            K_CLEAR: begin
                foreach (src_bins[i]) begin
                    src_bins[i] = '0;
                    ref_bins[i] = '0;
                end
                src_count = '0;
                ref_count = '0;
            end
            default: ;
        endcase
    endtask

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Present one word, hold it until taken, then maybe idle.
    task automatic send_word(logic [2:0] kind, logic [LVL_W-1:0] pix);
        int gap;
        start   <= 1'b1;
        i_kind  <= kind;
        i_pixel <= pix;
        do @(posedge i_clk); while (busy);
        predict_word(kind, pix);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Sender holds off until every mapped word is back.
    task automatic wait_results();
        start <= 1'b0;
        @(posedge i_clk);
        wait (mapped_q.size() == 0);
        @(posedge i_clk);
    endtask

    // Result side: one word per strobe cycle, no back-pressure.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (mapped_q.size() == 0) begin
                $error("mapped_value: unexpected word %0d", o_mapped_value);
                fail_count++;
            end else begin
                logic [LVL_W-1:0] want;
                want = mapped_q.pop_front();
                if (o_mapped_value !== want) begin
                    $error("mapped_value: expected %0d, got %0d", want, o_mapped_value);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles with no word taken and no result out.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [LVL_W-1:0] rand_pixel(int mode, int base);
        case (mode)
            0: return LVL_W'($urandom_range(0, 255));
            1: return LVL_W'(base + $urandom_range(0, 15));        // narrow window
            2: return $urandom_range(0, 1) ? 8'h00 : 8'hFF;        // extremes
            default: return LVL_W'(base + $urandom_range(0, 63));
        endcase
    endfunction

    // Fresh map is the identity.
    task automatic test_reset_identity();
        send_word(K_MAP, 8'd0);
        send_word(K_MAP, 8'd255);
        send_word(K_MAP, 8'hAA);
        send_word(K_MAP, 8'h55);
    endtask

    // Ignored kinds leave the map alone.
    task automatic test_spare_kinds();
        send_word(K_SPARE0, 8'hFF);
        send_word(K_SPARE1, 8'h00);
        send_word(K_SPARE2, 8'h3C);
        send_word(K_MAP, 8'h3C);
    endtask

    // Source counted but reference empty: map goes all zero.
    task automatic test_empty_build();
        send_word(K_SRC, 8'd7);
        send_word(K_SRC, 8'd200);
        send_word(K_BUILD, 8'd0);
        send_word(K_MAP, 8'd255);
        send_word(K_MAP, 8'd7);
    endtask

    // Real build with ties, then clear keeps the map until the next build.
    task automatic test_build_and_clear();
        send_word(K_REF, 8'd0);
        send_word(K_REF, 8'd255);
        send_word(K_SRC, 8'd255);
        send_word(K_SRC, 8'd128);
        send_word(K_BUILD, 8'd0);
        send_word(K_MAP, 8'd0);
        send_word(K_MAP, 8'd128);
        send_word(K_MAP, 8'd255);
        send_word(K_CLEAR, 8'd0);
        send_word(K_MAP, 8'd200);
        send_word(K_BUILD, 8'd0);
        send_word(K_MAP, 8'd200);
    endtask

    // Random frames: counts, one build, a stream of lookups.
    task automatic test_random_matching();
        int mode_s, mode_r, base_s, base_r, n_cnt, n_map, r;
        for (int frame = 0; frame < 5; frame++) begin
            no_gaps = (frame == 2);
            if (frame != 3) send_word(K_CLEAR, LVL_W'($urandom));
            mode_s = $urandom_range(0, 3);
            mode_r = $urandom_range(0, 3);
            base_s = $urandom_range(0, 192);
            base_r = $urandom_range(0, 192);
            n_cnt  = $urandom_range(80, 120);
            for (int k = 0; k < n_cnt; k++) begin
                r = $urandom_range(0, 99);
                if (r < 48) send_word(K_SRC, rand_pixel(mode_s, base_s));
                else if (r < 96) send_word(K_REF, rand_pixel(mode_r, base_r));
                else if (r < 98) send_word(3'($urandom_range(5, 7)), LVL_W'($urandom));
                else send_word(K_MAP, LVL_W'($urandom));
            end
            send_word(K_BUILD, LVL_W'($urandom));
            n_map = $urandom_range(40, 60);
            for (int k = 0; k < n_map; k++) send_word(K_MAP, LVL_W'($urandom));
            if (frame == 1) wait_results();
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        start     <= 1'b0;
        i_kind    <= K_SRC;
        i_pixel   <= '0;
        fail_count = 0;
        no_gaps    = 1'b0;
        idle_cycles = 0;
        src_count  = '0;
        ref_count  = '0;
        foreach (lut[i]) begin
            lut[i]      = LVL_W'(i);
            src_bins[i] = '0;
            ref_bins[i] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_identity();
        test_spare_kinds();
        test_empty_build();
        test_build_and_clear();
        test_random_matching();

        start <= 1'b0;
        wait (mapped_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && mapped_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
